### src/tmr_pkg.sv
// Shared types, codes and constants of the tile map pixel renderer.
// Used by every module of the block but tmr_ram; depends on nothing else.
package tmr_pkg;

    // Store sizes and fixed tile geometry.
    localparam int MAP_DEPTH_DEF  = 16384;
    localparam int TILE_DEPTH_DEF = 32768;
    localparam int TILE_SIZE      = 16;
    localparam int MAP_HEADER     = 3;
    localparam int GFX_HEADER     = 256;

    // Tile IDs at or past the tile count and above this value draw a solid color.
    localparam logic [7:0] SOLID_MIN = 8'hF0;
    localparam logic [7:0] HI_MASK   = 8'hF0;

    // Request kinds on the input stream.
    localparam logic [1:0] FUNC_MAP_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_TILE_LOAD = 2'd1;
    localparam logic [1:0] FUNC_RENDER    = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MAP_SELECTED = 3'd0;
    localparam logic [2:0] REG_SCROLL_X     = 3'd1;
    localparam logic [2:0] REG_SCROLL_Y     = 3'd2;
    localparam logic [2:0] REG_MAP_WIDTH    = 3'd3;
    localparam logic [2:0] REG_MAP_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_TILE_COUNT   = 3'd5;
    localparam logic [2:0] REG_WINDOW_WIDTH = 3'd6;

    // Operation carried down the pipeline; it is refined as lookups resolve.
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP        = 4'd0;
    localparam op_t OP_MAP_WR     = 4'd1;
    localparam op_t OP_TILE_WR    = 4'd2;
    localparam op_t OP_LOAD_OOR   = 4'd3;
    localparam op_t OP_SETUP_BAD  = 4'd4;
    localparam op_t OP_KEEP       = 4'd5;
    localparam op_t OP_CLEAR      = 4'd6;
    localparam op_t OP_LOOKUP     = 4'd7;
    localparam op_t OP_SOLID      = 4'd8;
    localparam op_t OP_RENDER_OOR = 4'd9;
    localparam op_t OP_PIXEL      = 4'd10;

    typedef struct packed {
        logic              map_selected;
        logic signed [15:0] scroll_x;
        logic signed [15:0] scroll_y;
        logic [7:0]        map_width;
        logic [7:0]        map_height;
        logic [7:0]        tile_count;
        logic [9:0]        window_width;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] load_address;
        logic [7:0]  load_value;
        logic [9:0]  column;
        logic [9:0]  row;
        logic [7:0]  frame_byte;
    } item_t;

    // Bundle handed from the coordinate stages to the map lookup.
    typedef struct packed {
        op_t         op;
        logic [15:0] prod;
        logic [7:0]  tx;
        logic [3:0]  xl;
        logic [3:0]  yl;
        logic [7:0]  frame;
        logic [15:0] addr;
        logic [7:0]  value;
    } mp_t;

    // Bundle handed from the map lookup to the tile lookup.
    typedef struct packed {
        op_t         op;
        logic [3:0]  xl;
        logic [3:0]  yl;
        logic [7:0]  frame;
        logic [15:0] addr;
        logic [7:0]  value;
    } tl_t;

endpackage

### src/tmr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the map store and the tile graphics store.
module tmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/tmr_coord.sv
// Front stages of the renderer: input register, setup and clipping checks,
// map coordinates and the map row product. Depends on tmr_pkg.
module tmr_coord import tmr_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  item_t in_item,
    input  cfg_t  cfg,
    output logic  out_valid,
    output mp_t   out_bundle
);

    item_t       s1_reg;
    logic        s1_valid_reg;

    logic        s2_valid_reg;
    op_t         s2_op_reg;
    logic [7:0]  s2_tx_reg;
    logic [7:0]  s2_ty_reg;
    logic [3:0]  s2_xl_reg;
    logic [3:0]  s2_yl_reg;
    logic [7:0]  s2_frame_reg;
    logic [15:0] s2_addr_reg;
    logic [7:0]  s2_val_reg;

    logic        s3_valid_reg;
    mp_t         s3_reg;

    logic [15:0] wpx;
    logic [15:0] hpx;
    logic [15:0] mx;
    logic [15:0] my;
    logic        bad_setup;
    logic        col_past;
    logic        outside;
    op_t         s2_op_next;
    logic [15:0] prod;

    // Valid bits move together on every advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Map pixel position and the clipping tests against the map size.
    always_comb
    begin
        wpx = {4'b0, cfg.map_width, 4'b0};
        hpx = {4'b0, cfg.map_height, 4'b0};
        mx  = {1'b0, cfg.scroll_x[14:0]} + {6'b0, s1_reg.column};
        my  = {1'b0, cfg.scroll_y[14:0]} + {6'b0, s1_reg.row};
        bad_setup = !cfg.map_selected || cfg.scroll_x[15] || cfg.scroll_y[15] ||
                    ({1'b0, cfg.scroll_x[14:0]} >= wpx) ||
                    ({1'b0, cfg.scroll_y[14:0]} >= hpx) ||
                    (cfg.window_width < 10'(TILE_SIZE));
        col_past = s1_reg.column >= cfg.window_width;
        outside  = (mx >= wpx) || (my >= hpx);
    end

    // Decode the request kind and the render special cases.
    always_comb
    begin
        unique case (s1_reg.func)
            FUNC_MAP_LOAD:  s2_op_next = OP_MAP_WR;
            FUNC_TILE_LOAD: s2_op_next = OP_TILE_WR;
            FUNC_RENDER:
            begin
                priority if (bad_setup) s2_op_next = OP_SETUP_BAD;
                else if (col_past)      s2_op_next = OP_KEEP;
                else if (outside)       s2_op_next = OP_CLEAR;
                else                    s2_op_next = OP_LOOKUP;
            end
            default:        s2_op_next = OP_NOP;
        endcase
    end

    // Row offset into the map: tile row times map width.
    assign prod = {8'b0, s2_ty_reg} * {8'b0, cfg.map_width};

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= in_item;

            s2_op_reg    <= s2_op_next;
            s2_tx_reg    <= mx[11:4];
            s2_ty_reg    <= my[11:4];
            s2_xl_reg    <= mx[3:0];
            s2_yl_reg    <= my[3:0];
            s2_frame_reg <= s1_reg.frame_byte;
            s2_addr_reg  <= s1_reg.load_address;
            s2_val_reg   <= s1_reg.load_value;

            s3_reg.op    <= s2_op_reg;
            s3_reg.prod  <= prod;
            s3_reg.tx    <= s2_tx_reg;
            s3_reg.xl    <= s2_xl_reg;
            s3_reg.yl    <= s2_yl_reg;
            s3_reg.frame <= s2_frame_reg;
            s3_reg.addr  <= s2_addr_reg;
            s3_reg.value <= s2_val_reg;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_bundle = s3_reg;

endmodule

### src/tmr_map_stage.sv
// Map store stage: map index, range check, map loads and the tile ID read.
// Depends on tmr_pkg and tmr_ram.
module tmr_map_stage import tmr_pkg::*; #(
    parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_valid,
    input  mp_t        in_bundle,
    output logic       out_valid,
    output tl_t        out_bundle,
    output logic [7:0] tile_id
);

    localparam int AW = $clog2(MAP_DEPTH);
    localparam logic [16:0] MAP_LIM = 17'(MAP_DEPTH);

    logic        s4_valid_reg;
    tl_t         s4_reg;
    logic [16:0] map_index;
    logic        index_oor;
    logic        load_oor;
    logic        map_we;
    op_t         op_next;

    // Index of the tile ID byte and the store range checks.
    always_comb
    begin
        map_index = 17'(MAP_HEADER) + {1'b0, in_bundle.prod} + {9'b0, in_bundle.tx};
        index_oor = map_index >= MAP_LIM;
        load_oor  = {1'b0, in_bundle.addr} >= MAP_LIM;
        map_we    = adv && in_valid && (in_bundle.op == OP_MAP_WR) && !load_oor;
    end

    // Resolve map loads and out-of-range lookups.
    always_comb
    begin
        priority if (in_bundle.op == OP_MAP_WR)
            op_next = load_oor ? OP_LOAD_OOR : OP_NOP;
        else if ((in_bundle.op == OP_LOOKUP) && index_oor)
            op_next = OP_RENDER_OOR;
        else
            op_next = in_bundle.op;
    end

    tmr_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (in_bundle.addr[AW-1:0]),
        .wdata (in_bundle.value),
        .re    (adv),
        .raddr (map_index[AW-1:0]),
        .rdata (tile_id)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg.op    <= op_next;
            s4_reg.xl    <= in_bundle.xl;
            s4_reg.yl    <= in_bundle.yl;
            s4_reg.frame <= in_bundle.frame;
            s4_reg.addr  <= in_bundle.addr;
            s4_reg.value <= in_bundle.value;
        end
    end

    assign out_valid  = s4_valid_reg;
    assign out_bundle = s4_reg;

endmodule

### src/tmr_tile_stage.sv
// Tile store stage: tile ID rules, graphics index, tile loads, pixel
// select and the output register. Depends on tmr_pkg and tmr_ram.
module tmr_tile_stage import tmr_pkg::*; #(
    parameter int TILE_DEPTH = TILE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_valid,
    input  tl_t        in_bundle,
    input  logic [7:0] tile_id,
    input  logic [7:0] tile_count,
    output logic       out_valid,
    output logic [7:0] pixel_out,
    output logic [1:0] status
);

    localparam int AW = $clog2(TILE_DEPTH);
    localparam logic [16:0] TILE_LIM = 17'(TILE_DEPTH);

    logic        s5_valid_reg;
    op_t         s5_op_reg;
    logic        s5_xodd_reg;
    logic [3:0]  s5_nib_reg;
    logic [7:0]  s5_frame_reg;

    logic        out_valid_reg;
    logic [7:0]  pixel_reg;
    logic [1:0]  status_reg;

    logic [15:0] gfx_index;
    logic        gfx_oor;
    logic        load_oor;
    logic        tile_we;
    op_t         op_next;
    logic [7:0]  gfx_byte;
    logic [7:0]  pixel_next;
    logic [1:0]  status_next;

    // Graphics byte index of the pixel pair and the store range checks.
    always_comb
    begin
        gfx_index = 16'(GFX_HEADER) + {1'b0, tile_id, 7'b0} +
                    {9'b0, in_bundle.yl, 3'b0} + {13'b0, in_bundle.xl[3:1]};
        gfx_oor   = {1'b0, gfx_index} >= TILE_LIM;
        load_oor  = {1'b0, in_bundle.addr} >= TILE_LIM;
        tile_we   = adv && in_valid && (in_bundle.op == OP_TILE_WR) && !load_oor;
    end

    // Tile loads and tile ID rules: graphic tile, solid color, transparent or out of range.
    always_comb
    begin
        priority if (in_bundle.op == OP_TILE_WR)
            op_next = load_oor ? OP_LOAD_OOR : OP_NOP;
        else if (in_bundle.op == OP_LOOKUP)
        begin
            priority if (tile_id >= tile_count)
                op_next = (tile_id > SOLID_MIN) ? OP_SOLID : OP_KEEP;
            else if (gfx_oor)
                op_next = OP_RENDER_OOR;
            else
                op_next = OP_PIXEL;
        end
        else
            op_next = in_bundle.op;
    end

    tmr_ram #(
        .WIDTH (8),
        .DEPTH (TILE_DEPTH)
    ) u_tile_ram (
        .clk   (clk),
        .we    (tile_we),
        .waddr (in_bundle.addr[AW-1:0]),
        .wdata (in_bundle.value),
        .re    (adv),
        .raddr (gfx_index[AW-1:0]),
        .rdata (gfx_byte)
    );

    // Final result; the left pixel sits in the high nibble.
    always_comb
    begin
        unique case (s5_op_reg)
            OP_LOAD_OOR:
            begin
                pixel_next  = 8'h00;
                status_next = ST_RANGE;
            end
            OP_SETUP_BAD:
            begin
                pixel_next  = s5_frame_reg;
                status_next = ST_SETUP;
            end
            OP_KEEP:
            begin
                pixel_next  = s5_frame_reg;
                status_next = ST_OK;
            end
            OP_CLEAR:
            begin
                pixel_next  = s5_frame_reg & HI_MASK;
                status_next = ST_OK;
            end
            OP_SOLID:
            begin
                pixel_next  = {s5_frame_reg[7:4], s5_nib_reg};
                status_next = ST_OK;
            end
            OP_RENDER_OOR:
            begin
                pixel_next  = s5_frame_reg;
                status_next = ST_RANGE;
            end
            OP_PIXEL:
            begin
                pixel_next  = {s5_frame_reg[7:4],
                               s5_xodd_reg ? gfx_byte[3:0] : gfx_byte[7:4]};
                status_next = ST_OK;
            end
            default:
            begin
                pixel_next  = 8'h00;
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_valid_reg  <= in_valid;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_op_reg    <= op_next;
            s5_xodd_reg  <= in_bundle.xl[0];
            s5_nib_reg   <= tile_id[3:0];
            s5_frame_reg <= in_bundle.frame;
            pixel_reg    <= pixel_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_reg;
    assign status    = status_reg;

endmodule

### src/tilemap_pixel_renderer.sv
// Scrolling tile map renderer: takes one request per clock while the output
// is not held and returns one result per request, in order. The pipeline
// has six register stages: input, clipping, row product, map read, tile
// graphics read and output; both store reads are registered. When the
// output is held by the sink the whole pipeline holds, so s_tready follows
// "output empty or being taken". The map and tile stores have no reset
// value and are not cleared; load every entry a render will touch first.
// Configuration is written through the always-ready cfg channel; the user
// must write it only while no request is in flight, not enforced by the
// block. Depends on tmr_pkg, tmr_coord, tmr_map_stage and tmr_tile_stage.
module tilemap_pixel_renderer import tmr_pkg::*; #(
    parameter int MAP_DEPTH  = MAP_DEPTH_DEF,
    parameter int TILE_DEPTH = TILE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // load_address[15:0], load_value[23:16], column[33:24], row[43:34],
    // frame_byte[51:44], zero fill [55:52]
    input  logic [55:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_out[7:0]
    output logic [7:0]  m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic              map_selected_reg;
    logic signed [15:0] scroll_x_reg;
    logic signed [15:0] scroll_y_reg;
    logic [7:0]        map_width_reg;
    logic [7:0]        map_height_reg;
    logic [7:0]        tile_count_reg;
    logic [9:0]        window_width_reg;

    cfg_t  cfg;
    item_t in_item;
    logic  adv;
    logic  mp_valid;
    mp_t   mp_bundle;
    logic  tl_valid;
    tl_t   tl_bundle;
    logic [7:0] tile_id;

    // Pipeline moves whenever the output register is free or being taken.
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_selected_reg <= 1'b0;
            scroll_x_reg     <= '0;
            scroll_y_reg     <= '0;
            map_width_reg    <= '0;
            map_height_reg   <= '0;
            tile_count_reg   <= '0;
            window_width_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAP_SELECTED: map_selected_reg <= cfg_data[0];
                REG_SCROLL_X:     scroll_x_reg     <= cfg_data;
                REG_SCROLL_Y:     scroll_y_reg     <= cfg_data;
                REG_MAP_WIDTH:    map_width_reg    <= cfg_data[7:0];
                REG_MAP_HEIGHT:   map_height_reg   <= cfg_data[7:0];
                REG_TILE_COUNT:   tile_count_reg   <= cfg_data[7:0];
                REG_WINDOW_WIDTH: window_width_reg <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.map_selected = map_selected_reg;
        cfg.scroll_x     = scroll_x_reg;
        cfg.scroll_y     = scroll_y_reg;
        cfg.map_width    = map_width_reg;
        cfg.map_height   = map_height_reg;
        cfg.tile_count   = tile_count_reg;
        cfg.window_width = window_width_reg;
    end

    // Unpack the request.
    always_comb
    begin
        in_item.func         = s_tuser;
        in_item.load_address = s_tdata[15:0];
        in_item.load_value   = s_tdata[23:16];
        in_item.column       = s_tdata[33:24];
        in_item.row          = s_tdata[43:34];
        in_item.frame_byte   = s_tdata[51:44];
    end

    tmr_coord u_coord (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_item    (in_item),
        .cfg        (cfg),
        .out_valid  (mp_valid),
        .out_bundle (mp_bundle)
    );

    tmr_map_stage #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_map_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (mp_valid),
        .in_bundle  (mp_bundle),
        .out_valid  (tl_valid),
        .out_bundle (tl_bundle),
        .tile_id    (tile_id)
    );

    tmr_tile_stage #(
        .TILE_DEPTH (TILE_DEPTH)
    ) u_tile_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (tl_valid),
        .in_bundle  (tl_bundle),
        .tile_id    (tile_id),
        .tile_count (tile_count_reg),
        .out_valid  (m_tvalid),
        .pixel_out  (m_tdata),
        .status     (m_tuser)
    );

endmodule

### src/tmr_checker.sv
// Port-level checks of the tile map pixel renderer, bound to its top level.
// Depends on tmr_pkg and on the tilemap_pixel_renderer port list.
module tmr_checker import tmr_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // No result is offered in the cycle after reset has been seen at a clock edge.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Requests are taken whenever the output is free or being taken.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("request refused while pipeline can move");

    // A stalled output stalls the request side too.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while pipeline is held");

    // Status of an offered result is one of the defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_SETUP || m_tuser == ST_RANGE))
        else $error("undefined status code");

endmodule

bind tilemap_pixel_renderer tmr_checker u_tmr_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the tile map pixel renderer: directed cases, random traffic
// and backpressure, checked against a behavioral predictor kept inside the bench.
// Depends on tmr_pkg and tilemap_pixel_renderer.
module testbench;
    import tmr_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAP_DEPTH    = MAP_DEPTH_DEF;
    localparam int TILE_DEPTH   = TILE_DEPTH_DEF;
    localparam int TILE_BYTES   = TILE_SIZE * TILE_SIZE / 2;

    // Request kind that the block ignores, and a register index past the list.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] REG_SPARE   = 3'd7;

    typedef struct packed {
        logic [7:0] pixel;
        logic [1:0] status;
    } pixel_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Predictor state: configuration, store images and which entries hold data.
    cfg_t          cfg_now = '0;
    bit [7:0]      map_image   [MAP_DEPTH];
    bit            map_loaded  [MAP_DEPTH];
    bit [7:0]      tile_image  [TILE_DEPTH];
    bit            tile_loaded [TILE_DEPTH];
    pixel_result_t expected_pixels [$];
    pixel_result_t oldest;

    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int sent_count    = 0;
    int render_count  = 0;
    int checked_count = 0;
    int config_count  = 0;

    tilemap_pixel_renderer #(
        .MAP_DEPTH  (MAP_DEPTH),
        .TILE_DEPTH (TILE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tilemap_pixel_renderer verification failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted down once per cycle.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
    end

    // Result side ready: random stalls, forced low during a hold-off.
    always @(negedge clk)
    begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare every accepted result with the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual pixel_out %02h status %0d",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                oldest = expected_pixels.pop_front();
                checked_count++;
                if (m_tdata !== oldest.pixel)
                begin
                    error_count++;
                    $display("%0t: pixel_out mismatch: expected %02h, actual %02h",
                             $time, oldest.pixel, m_tdata);
                end
                if (m_tuser !== oldest.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, oldest.status, m_tuser);
                end
            end
        end
    end

    // Follow one render request through the pixel rule. Returns the result and the
    // store entries it reads, or -1 where a store is not read.
    function automatic pixel_result_t trace_render(item_t rq, output int map_idx,
                                                   output int gfx_idx);
        pixel_result_t r;
        int         sx;
        int         sy;
        int         wpx;
        int         hpx;
        int         mx;
        int         my;
        int         mi;
        int         gi;
        logic [7:0] id;
        logic [7:0] g;
        map_idx  = -1;
        gfx_idx  = -1;
        r.pixel  = rq.frame_byte;
        r.status = ST_OK;
        sx  = $signed(cfg_now.scroll_x);
        sy  = $signed(cfg_now.scroll_y);
        wpx = cfg_now.map_width * TILE_SIZE;
        hpx = cfg_now.map_height * TILE_SIZE;
        if (!cfg_now.map_selected || sx < 0 || sy < 0 || sx >= wpx || sy >= hpx ||
            cfg_now.window_width < 16)
        begin
            r.status = ST_SETUP;
            return r;
        end
        if (rq.column >= cfg_now.window_width)
            return r;
        mx = sx + rq.column;
        my = sy + rq.row;
        if (mx >= wpx || my >= hpx)
        begin
            r.pixel = rq.frame_byte & HI_MASK;
            return r;
        end
        mi = MAP_HEADER + (my >> 4) * cfg_now.map_width + (mx >> 4);
        if (mi >= MAP_DEPTH)
        begin
            r.status = ST_RANGE;
            return r;
        end
        map_idx = mi;
        id = map_image[mi];
        // IDs past the tile count are either solid colors or see-through.
        if (id >= cfg_now.tile_count)
        begin
            if (id > SOLID_MIN)
                r.pixel = {rq.frame_byte[7:4], id[3:0]};
            return r;
        end
        gi = GFX_HEADER + id * TILE_BYTES + (my & 15) * 8 + ((mx & 15) >> 1);
        if (gi >= TILE_DEPTH)
        begin
            r.status = ST_RANGE;
            return r;
        end
        gfx_idx = gi;
        g = tile_image[gi];
        r.pixel = {rq.frame_byte[7:4], mx[0] ? g[3:0] : g[7:4]};
        return r;
    endfunction

    // Expected result of one accepted request; loads update the store images.
    function automatic pixel_result_t predict_pixel_result(item_t rq);
        pixel_result_t r;
        int            mi;
        int            gi;
        r.pixel  = 8'h00;
        r.status = ST_OK;
        case (rq.func)
            FUNC_MAP_LOAD:
                if (rq.load_address < MAP_DEPTH)
                begin
                    map_image[rq.load_address]  = rq.load_value;
                    map_loaded[rq.load_address] = 1'b1;
                end
                else
                    r.status = ST_RANGE;
            FUNC_TILE_LOAD:
                if (rq.load_address < TILE_DEPTH)
                begin
                    tile_image[rq.load_address]  = rq.load_value;
                    tile_loaded[rq.load_address] = 1'b1;
                end
                else
                    r.status = ST_RANGE;
            FUNC_RENDER:
                r = trace_render(rq, mi, gi);
            default: ;
        endcase
        return r;
    endfunction

    function automatic item_t make_item(logic [1:0] func, logic [15:0] addr,
                                        logic [7:0] value, logic [9:0] col,
                                        logic [9:0] row, logic [7:0] fb);
        item_t rq;
        rq.func         = func;
        rq.load_address = addr;
        rq.load_value   = value;
        rq.column       = col;
        rq.row          = row;
        rq.frame_byte   = fb;
        return rq;
    endfunction

    // Tile ID for a map entry: mostly drawn tiles, then solid colors and the rest.
    function automatic logic [7:0] pick_tile_id();
        logic [7:0] id;
        case ($urandom_range(3))
            0, 1: id = (cfg_now.tile_count != 0) ? 8'($urandom_range(cfg_now.tile_count - 1))
                                                 : 8'($urandom);
            2: id = 8'($urandom_range(255, 241));
            default: id = 8'($urandom);
        endcase
        return id;
    endfunction

    // Offer one request with random gaps and record its expectation on acceptance.
    task automatic send_request(item_t rq);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.func;
        s_tdata  <= {4'h0, rq.frame_byte, rq.row, rq.column, rq.load_value, rq.load_address};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_pixels.push_back(predict_pixel_result(rq));
        sent_count++;
    endtask

    task automatic load_store(logic [1:0] func, logic [15:0] addr, logic [7:0] value);
        send_request(make_item(func, addr, value, 10'($urandom), 10'($urandom),
                               8'($urandom)));
    endtask

    // Render one pixel, first loading any store entry it reads that holds no data.
    task automatic render_pixel(logic [9:0] col, logic [9:0] row, logic [7:0] fb);
        item_t         rq;
        pixel_result_t ignored;
        int            mi;
        int            gi;
        rq = make_item(FUNC_RENDER, 16'($urandom), 8'($urandom), col, row, fb);
        ignored = trace_render(rq, mi, gi);
        if (mi >= 0 && !map_loaded[mi])
            load_store(FUNC_MAP_LOAD, mi[15:0], pick_tile_id());
        ignored = trace_render(rq, mi, gi);
        if (gi >= 0 && !tile_loaded[gi])
            load_store(FUNC_TILE_LOAD, gi[15:0], 8'($urandom));
        send_request(rq);
        render_count++;
    endtask

    // Release the input and wait until every result is back and the pipeline is empty.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MAP_SELECTED: cfg_now.map_selected = data[0];
            REG_SCROLL_X:     cfg_now.scroll_x     = data;
            REG_SCROLL_Y:     cfg_now.scroll_y     = data;
            REG_MAP_WIDTH:    cfg_now.map_width    = data[7:0];
            REG_MAP_HEIGHT:   cfg_now.map_height   = data[7:0];
            REG_TILE_COUNT:   cfg_now.tile_count   = data[7:0];
            REG_WINDOW_WIDTH: cfg_now.window_width = data[9:0];
            default: ;
        endcase
    endtask

    // Write every register once the block is idle; unused upper bits carry noise.
    task automatic apply_config(cfg_t c);
        logic [15:0] junk;
        wait_idle();
        junk = 16'($urandom);
        write_reg(REG_MAP_SELECTED, {junk[15:1], c.map_selected});
        write_reg(REG_SCROLL_X, c.scroll_x);
        write_reg(REG_SCROLL_Y, c.scroll_y);
        write_reg(REG_MAP_WIDTH, {junk[15:8], c.map_width});
        write_reg(REG_MAP_HEIGHT, {junk[7:0], c.map_height});
        write_reg(REG_TILE_COUNT, {junk[11:4], c.tile_count});
        write_reg(REG_WINDOW_WIDTH, {junk[5:0], c.window_width});
        write_reg(REG_SPARE, 16'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        config_count++;
    endtask

    function automatic cfg_t base_config();
        cfg_t c;
        c.map_selected = 1'b1;
        c.scroll_x     = 16'sd0;
        c.scroll_y     = 16'sd0;
        c.map_width    = 8'd2;
        c.map_height   = 8'd2;
        c.tile_count   = 8'd4;
        c.window_width = 10'd1023;
        return c;
    endfunction

    // Mostly small valid maps, with the size extremes and now and then a broken setup.
    function automatic cfg_t make_random_cfg();
        cfg_t c;
        int   wpx;
        int   hpx;
        c.map_selected = 1'b1;
        case ($urandom_range(9))
            0: c.map_width = 8'd255;
            1: c.map_width = 8'd1;
            default: c.map_width = 8'($urandom_range(6, 1));
        endcase
        case ($urandom_range(9))
            0: c.map_height = 8'd255;
            1: c.map_height = 8'd1;
            default: c.map_height = 8'($urandom_range(6, 1));
        endcase
        case ($urandom_range(5))
            0: c.tile_count = 8'd0;
            1: c.tile_count = 8'd255;
            default: c.tile_count = 8'($urandom_range(16, 1));
        endcase
        case ($urandom_range(5))
            0: c.window_width = 10'd16;
            1: c.window_width = 10'd1023;
            default: c.window_width = 10'($urandom_range(1023, 16));
        endcase
        wpx = c.map_width * TILE_SIZE;
        hpx = c.map_height * TILE_SIZE;
        case ($urandom_range(5))
            0: c.scroll_x = 16'sd0;
            1: c.scroll_x = 16'(wpx - 1);
            default: c.scroll_x = 16'($urandom_range(wpx - 1, 0));
        endcase
        case ($urandom_range(5))
            0: c.scroll_y = 16'sd0;
            1: c.scroll_y = 16'(hpx - 1);
            default: c.scroll_y = 16'($urandom_range(hpx - 1, 0));
        endcase
        if ($urandom_range(9) == 0)
        begin
            c.map_selected = 1'($urandom);
            c.scroll_x     = 16'($urandom);
            c.scroll_y     = 16'($urandom);
            c.map_width    = 8'($urandom);
            c.window_width = 10'($urandom);
        end
        return c;
    endfunction

    // One random request: mostly renders aimed at the map, then loads and noise.
    task automatic random_request();
        int         sel;
        int         area;
        int         span;
        int         ntiles;
        logic [9:0] col;
        logic [9:0] row;
        sel    = $urandom_range(99);
        area   = cfg_now.map_width * cfg_now.map_height;
        ntiles = (cfg_now.tile_count != 0) ? cfg_now.tile_count : 1;
        if (sel < 60)
        begin
            span = cfg_now.map_height * TILE_SIZE - $signed(cfg_now.scroll_y);
            if (span > 1024)
                span = 1024;
            col = 10'($urandom);
            row = 10'($urandom);
            if (cfg_now.window_width != 0 && $urandom_range(9) < 8)
                col = 10'($urandom_range(cfg_now.window_width - 1));
            if (span > 0 && $urandom_range(9) < 8)
                row = 10'($urandom_range(span - 1));
            render_pixel(col, row, 8'($urandom));
        end
        else if (sel < 72)
            load_store(FUNC_MAP_LOAD,
                       16'((area > 0) ? MAP_HEADER + $urandom_range(area - 1) : $urandom),
                       pick_tile_id());
        else if (sel < 80)
            load_store(FUNC_TILE_LOAD,
                       16'(GFX_HEADER + $urandom_range(ntiles - 1) * TILE_BYTES +
                           $urandom_range(TILE_BYTES - 1)), 8'($urandom));
        else if (sel < 92)
            load_store($urandom_range(1) ? FUNC_TILE_LOAD : FUNC_MAP_LOAD, 16'($urandom),
                       8'($urandom));
        else
            send_request(make_item(FUNC_UNUSED, 16'($urandom), 8'($urandom), 10'($urandom),
                                   10'($urandom), 8'($urandom)));
    endtask

    // Requests under the reset configuration: setup reject, ignored kind, load range.
    task automatic test_reset_defaults();
        render_pixel(10'd0, 10'd0, 8'hFF);
        send_request(make_item(FUNC_UNUSED, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF, 8'hFF));
        load_store(FUNC_MAP_LOAD, 16'(MAP_DEPTH), 8'h5A);
        load_store(FUNC_MAP_LOAD, 16'hFFFF, 8'hFF);
        load_store(FUNC_TILE_LOAD, 16'(TILE_DEPTH), 8'hA5);
        load_store(FUNC_TILE_LOAD, 16'hFFFF, 8'h00);
        load_store(FUNC_MAP_LOAD, 16'd0, 8'h00);
    endtask

    // Tile pixels, solid colors, see-through IDs, clipping and the window edge.
    task automatic test_pixel_sources();
        apply_config(base_config());
        load_store(FUNC_MAP_LOAD, 16'(MAP_HEADER + 0), 8'd1);
        load_store(FUNC_MAP_LOAD, 16'(MAP_HEADER + 1), 8'hFF);
        load_store(FUNC_MAP_LOAD, 16'(MAP_HEADER + 2), SOLID_MIN);
        load_store(FUNC_MAP_LOAD, 16'(MAP_HEADER + 3), 8'd5);
        load_store(FUNC_TILE_LOAD, 16'(GFX_HEADER + TILE_BYTES), 8'hA5);
        render_pixel(10'd0, 10'd0, 8'h00);
        render_pixel(10'd1, 10'd0, 8'hFF);
        render_pixel(10'd15, 10'd15, 8'h96);
        render_pixel(10'd16, 10'd0, 8'h30);
        render_pixel(10'd0, 10'd16, 8'h7C);
        render_pixel(10'd31, 10'd31, 8'h12);
        render_pixel(10'd32, 10'd0, 8'hFF);
        render_pixel(10'd0, 10'd1023, 8'hAB);
        render_pixel(10'd1023, 10'd0, 8'h55);
        // Lowest solid color ID.
        load_store(FUNC_MAP_LOAD, 16'(MAP_HEADER + 1), 8'hF1);
        render_pixel(10'd17, 10'd3, 8'hC0);
    endtask

    // Each way a setup can be rejected, then the narrowest accepted window.
    task automatic test_bad_setup();
        cfg_t c;
        for (int k = 0; k < 6; k++)
        begin
            c = base_config();
            case (k)
                0: c.scroll_x     = -16'sd32768;
                1: c.scroll_y     = -16'sd1;
                2: c.scroll_x     = 16'sd32;
                3: c.scroll_y     = 16'sd32;
                4: c.window_width = 10'd15;
                default: c.map_selected = 1'b0;
            endcase
            apply_config(c);
            render_pixel(10'd0, 10'd0, 8'($urandom));
        end
        c = base_config();
        c.window_width = 10'd16;
        apply_config(c);
        render_pixel(10'd15, 10'd0, 8'hE7);
        render_pixel(10'd16, 10'd0, 8'hE7);
    endtask

    // Map and tile graphics indexes at and past the end of their stores.
    task automatic test_store_range();
        cfg_t c;
        c = base_config();
        c.map_width  = 8'd255;
        c.map_height = 8'd255;
        c.tile_count = 8'd255;
        c.scroll_y   = 16'sd4079;
        apply_config(c);
        render_pixel(10'd0, 10'd0, 8'h3C);
        c.scroll_y = 16'sd0;
        apply_config(c);
        load_store(FUNC_MAP_LOAD, 16'(MAP_HEADER + 0), 8'd254);
        load_store(FUNC_MAP_LOAD, 16'(MAP_HEADER + 1), 8'd253);
        render_pixel(10'd0, 10'd0, 8'h81);
        render_pixel(10'd16, 10'd0, 8'h42);
        render_pixel(10'd31, 10'd15, 8'h24);
    endtask

    task automatic test_random_traffic(int n_items, int src_pct, int snk_pct);
        int done;
        done = 0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        while (done < n_items)
        begin
            apply_config(make_random_cfg());
            repeat (40)
            begin
                random_request();
                done++;
            end
        end
    endtask

    // The receiver stalls long enough to fill the pipeline while requests keep coming;
    // then the sender waits for every result before a short final burst.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        apply_config(make_random_cfg());
        @(negedge clk);
        hold_left = HOLD_CYCLES;
        repeat (60)
            random_request();
        wait_idle();
        repeat (20)
            random_request();
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_pixel_sources();
        test_bad_setup();
        test_store_range();
        test_random_traffic(160, 6, 58);
        test_random_traffic(160, 58, 6);
        test_random_traffic(160, 0, 0);
        test_backpressure();

        wait_idle();
        $display("Covered %0d requests (%0d renders) over %0d register settings,",
                 sent_count, render_count, config_count);
        $display("with %0d results checked under source and sink stalls and a long hold-off.",
                 checked_count);
        if (error_count == 0)
            $display("tilemap_pixel_renderer verification clean");
        else
            $display("tilemap_pixel_renderer verification failed");
        $finish;
    end

endmodule
